[design/bui_pkg.sv]
// Shared types and constants for the bilinear upscaler.
// No dependencies; imported by every other design file but bui_ram.

package bui_pkg;

  localparam int MAX_WIDTH_DEF = 2048;  // default line store depth
  localparam int MAX_SCALE     = 4;     // largest scale factor per axis
  localparam int MAX_HEIGHT    = 8192;  // largest source height

  localparam int CH_W   = 8;
  localparam int PIX_W  = 4 * CH_W;
  localparam int SCL_W  = 3;
  localparam int CHN_W  = 3;
  localparam int DIM_W  = 14;   // effective width / height
  localparam int ROW_W  = 13;
  localparam int DST_W  = 16;   // internal destination coordinates
  localparam int DX_W   = 13;
  localparam int DY_W   = 15;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // fraction 0 .. 2s-1 (pass-through uses 2), plus room for one step
  localparam int FRAC_W = $clog2(2 * MAX_SCALE + 2);
  localparam int WGT_W  = $clog2(2 * MAX_SCALE + 1);
  localparam int WP_W   = $clog2(4 * MAX_SCALE * MAX_SCALE + 1);
  localparam int ACC_W  = $clog2(255 * 4 * MAX_SCALE * MAX_SCALE
                                 + 2 * MAX_SCALE * MAX_SCALE + 1);

  // register indexes
  localparam logic [1:0] REG_SCALE    = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  // effective configuration, already clamped
  typedef struct packed {
    logic [SCL_W-1:0] scale;
    logic [CHN_W-1:0] chans;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             restart;  // register write: frame restarts
  } cfg_t;

  // one destination pixel request from the sequencer to the MAC unit
  typedef struct packed {
    logic              valid;
    logic [PIX_W-1:0]  tl;
    logic [PIX_W-1:0]  tr;
    logic [PIX_W-1:0]  bl;
    logic [PIX_W-1:0]  br;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [SCL_W-1:0]  scale;
    logic [DST_W-1:0]  dx;
    logic [DST_W-1:0]  dy;
    logic              last;
  } mac_req_t;

endpackage

[design/bui_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bui_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bui_cfg.sv]
// APB register file: scale, channel count, source width and height.
// Depends on bui_pkg; hands clamped values and a restart strobe on.

module bui_cfg import bui_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SCL_W-1:0] scale_factor;
  logic [CHN_W-1:0] channel_count;
  logic [11:0]      source_width;
  logic [13:0]      source_height;
  logic             wr;
  logic [DIM_W-1:0] w0;
  logic [DIM_W-1:0] h0;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCL_W'(4);
      channel_count <= CHN_W'(4);
      source_width  <= 12'd2048;
      source_height <= 14'd8192;
    end else if (wr) begin
      case (paddr[3:2])
        REG_SCALE:    scale_factor  <= pwdata[SCL_W-1:0];
        REG_CHANNELS: channel_count <= pwdata[CHN_W-1:0];
        REG_WIDTH:    source_width  <= pwdata[11:0];
        REG_HEIGHT:   source_height <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCALE:    prdata = DATA_W'(scale_factor);
      REG_CHANNELS: prdata = DATA_W'(channel_count);
      REG_WIDTH:    prdata = DATA_W'(source_width);
      REG_HEIGHT:   prdata = DATA_W'(source_height);
      default:      prdata = '0;
    endcase
  end

  // clamp to the supported ranges
  always_comb begin
    w0 = (source_width == '0) ? DIM_W'(1) : DIM_W'(source_width);
    h0 = (source_height == '0) ? DIM_W'(1) : DIM_W'(source_height);

    if (scale_factor == '0) begin
      cfg.scale = SCL_W'(1);
    end else if (scale_factor > SCL_W'(MAX_SCALE)) begin
      cfg.scale = SCL_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale_factor;
    end

    if (channel_count == '0) begin
      cfg.chans = CHN_W'(1);
    end else if (channel_count > CHN_W'(4)) begin
      cfg.chans = CHN_W'(4);
    end else begin
      cfg.chans = channel_count;
    end

    cfg.width   = (w0 > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w0;
    cfg.height  = (h0 > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h0;
    cfg.restart = wr;
  end

endmodule

[design/bui_seq.sv]
// Sequencer: frame counters, line store, left neighbours and the
// destination walk. Depends on bui_pkg and bui_ram.

module bui_seq import bui_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CH_W-1:0] in_ch0,
  input  logic [CH_W-1:0] in_ch1,
  input  logic [CH_W-1:0] in_ch2,
  input  logic [CH_W-1:0] in_ch3,
  input  logic            adv,
  output mac_req_t        req
);

  localparam int CW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_RUN} state_t;

  typedef struct packed {
    logic [DST_W-1:0]  lo;
    logic [DST_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
    logic              flag;
  } axis_t;

  // destination range on one axis whose far neighbour is source index p
  function automatic axis_t axis_setup(input logic [DST_W-1:0] p,
                                       input logic [DST_W-1:0] n,
                                       input logic [SCL_W-1:0] s);
    logic [DST_W-1:0] sp;
    logic [DST_W-1:0] up;
    logic [DST_W-1:0] dn;
    logic [DST_W:0]   ns;
    axis_t            a;
    sp = DST_W'(p) * DST_W'(s);
    ns = (DST_W+1)'(n) * (DST_W+1)'(s);
    up = DST_W'((s + SCL_W'(1)) >> 1);
    dn = DST_W'(s >> 1);
    if (s == SCL_W'(1)) begin
      // pass through: full weight on the current pixel
      a.lo   = p;
      a.hi   = p;
      a.frac = FRAC_W'(2);
      a.flag = 1'b1;
    end else begin
      a.lo   = (sp >= up) ? sp - up : '0;
      a.hi   = (p == n - DST_W'(1)) ? DST_W'(ns - (DST_W+1)'(1))
                                    : sp + dn - DST_W'(1);
      a.frac = (p == '0) ? FRAC_W'(s) + FRAC_W'(1)
                         : (s[0] ? FRAC_W'(0) : FRAC_W'(1));
      a.flag = (p == '0);
    end
    return a;
  endfunction

  // advance the fraction by 1/s; wrapping means the near neighbour is p
  function automatic logic [FRAC_W:0] frac_step(input logic [FRAC_W-1:0] f,
                                                input logic [SCL_W-1:0]  s);
    logic [FRAC_W:0] nf;
    logic [FRAC_W:0] two_s;
    nf    = (FRAC_W+1)'(f) + (FRAC_W+1)'(2);
    two_s = (FRAC_W+1)'(s) << 1;
    if (nf >= two_s) begin
      return {1'b1, FRAC_W'(nf - two_s)};
    end
    return {1'b0, FRAC_W'(nf)};
  endfunction

  state_t            state;
  logic [CW-1:0]     col;
  logic [ROW_W-1:0]  row;
  logic [PIX_W-1:0]  cur;
  logic [PIX_W-1:0]  above;
  logic [PIX_W-1:0]  left_cur;
  logic [PIX_W-1:0]  left_above;
  logic [DST_W-1:0]  cd, cd_lo, cd_hi, rd, rd_hi;
  logic [FRAC_W-1:0] cf, cf_lo, rf;
  logic              cflag, cflag_lo, rflag;

  logic [PIX_W-1:0]  cur_in;
  logic [PIX_W-1:0]  rdata;
  logic [PIX_W-1:0]  top_r;
  logic [PIX_W-1:0]  top_l;
  axis_t             cax;
  axis_t             rax;
  logic [FRAC_W:0]   cstep;
  logic [FRAC_W:0]   rstep;
  logic              accept;
  logic              col_end;
  logic              row_end;

  assign in_stall = (state != ST_IDLE);
  assign accept   = (state == ST_IDLE) & in_valid;

  // unused channels enter as zero
  assign cur_in = {(cfg.chans >= CHN_W'(4)) ? in_ch3 : CH_W'(0),
                   (cfg.chans >= CHN_W'(3)) ? in_ch2 : CH_W'(0),
                   (cfg.chans >= CHN_W'(2)) ? in_ch1 : CH_W'(0),
                   in_ch0};

  assign cax   = axis_setup(DST_W'(col), DST_W'(cfg.width), cfg.scale);
  assign rax   = axis_setup(DST_W'(row), DST_W'(cfg.height), cfg.scale);
  assign cstep = frac_step(cf, cfg.scale);
  assign rstep = frac_step(rf, cfg.scale);

  assign col_end = (cd == cd_hi);
  assign row_end = (rd == rd_hi);

  bui_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (state == ST_FETCH),
    .waddr (col),
    .wdata (cur),
    .raddr (col),
    .rdata (rdata)
  );

  always_comb begin
    top_r     = rflag ? cur : above;
    top_l     = rflag ? left_cur : left_above;
    req.valid = (state == ST_RUN);
    req.tl    = cflag ? top_r : top_l;
    req.tr    = top_r;
    req.bl    = cflag ? cur : left_cur;
    req.br    = cur;
    req.fx    = cf;
    req.fy    = rf;
    req.scale = cfg.scale;
    req.dx    = cd;
    req.dy    = rd;
    req.last  = col_end & row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      col        <= '0;
      row        <= '0;
      left_cur   <= '0;
      left_above <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur      <= cur_in;
            cd       <= cax.lo;
            cd_lo    <= cax.lo;
            cd_hi    <= cax.hi;
            cf       <= cax.frac;
            cf_lo    <= cax.frac;
            cflag    <= cax.flag;
            cflag_lo <= cax.flag;
            rd       <= rax.lo;
            rd_hi    <= rax.hi;
            rf       <= rax.frac;
            rflag    <= rax.flag;
            state    <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          above <= rdata;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            if (col_end) begin
              cd    <= cd_lo;
              cf    <= cf_lo;
              cflag <= cflag_lo;
              rd    <= rd + DST_W'(1);
              rf    <= rstep[FRAC_W-1:0];
              rflag <= rflag | rstep[FRAC_W];
            end else begin
              cd    <= cd + DST_W'(1);
              cf    <= cstep[FRAC_W-1:0];
              cflag <= cflag | cstep[FRAC_W];
            end
            if (col_end & row_end) begin
              left_cur   <= cur;
              left_above <= above;
              if (DIM_W'(col) + DIM_W'(1) >= cfg.width) begin
                col <= '0;
                row <= (DIM_W'(row) + DIM_W'(1) >= cfg.height) ? '0
                                                               : row + ROW_W'(1);
              end else begin
                col <= col + CW'(1);
              end
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg.restart) begin
        col <= '0;
        row <= '0;
      end
    end
  end

endmodule

[design/bui_mac.sv]
// Shared multiply-accumulate unit: weights, four-tap sum, rounding.
// Depends on bui_pkg; holds the output register.

module bui_mac import bui_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  mac_req_t        req,
  output logic            adv,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [DX_W-1:0] dest_x,
  output logic [DY_W-1:0] dest_y,
  output logic [CH_W-1:0] out_ch0,
  output logic [CH_W-1:0] out_ch1,
  output logic [CH_W-1:0] out_ch2,
  output logic [CH_W-1:0] out_ch3,
  output logic            run_last
);

  localparam int RCP_W = 13;
  localparam int MUL_W = ACC_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP9 = RCP_W'(7282);  // 2^16 / 9, rounded up

  logic [WGT_W-1:0] wx0, wx1, wy0, wy1, two_s;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_tl, s1_tr, s1_bl, s1_br;
  logic [WP_W-1:0]  s1_w00, s1_w10, s1_w01, s1_w11;
  logic [SCL_W-1:0] s1_scale;
  logic [DST_W-1:0] s1_dx, s1_dy;
  logic             s1_last;

  logic             s2_valid;
  logic [ACC_W-1:0] s2_acc [4];
  logic [ACC_W-1:0] acc [4];
  logic [SCL_W-1:0] s2_scale;
  logic [DST_W-1:0] s2_dx, s2_dy;
  logic             s2_last;

  logic [ACC_W-1:0] half;
  logic [2:0]       sh;
  logic [ACC_W-1:0] pre [4];
  logic [MUL_W-1:0] prod [4];
  logic [CH_W-1:0]  res [4];

  assign adv = ~out_valid | ~out_stall;

  assign two_s = WGT_W'(req.scale) << 1;
  assign wx1   = WGT_W'(req.fx);
  assign wy1   = WGT_W'(req.fy);
  assign wx0   = two_s - wx1;
  assign wy0   = two_s - wy1;

  // four taps per channel
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = ACC_W'(s1_tl[c*CH_W +: CH_W]) * ACC_W'(s1_w00)
             + ACC_W'(s1_tr[c*CH_W +: CH_W]) * ACC_W'(s1_w10)
             + ACC_W'(s1_bl[c*CH_W +: CH_W]) * ACC_W'(s1_w01)
             + ACC_W'(s1_br[c*CH_W +: CH_W]) * ACC_W'(s1_w11);
    end
  end

  // divide by 4s^2 rounding half up; scale 3 divides by 9 via reciprocal
  always_comb begin
    case (s2_scale)
      SCL_W'(1): begin half = ACC_W'(2);  sh = 3'd2; end
      SCL_W'(2): begin half = ACC_W'(8);  sh = 3'd4; end
      SCL_W'(3): begin half = ACC_W'(18); sh = 3'd2; end
      default:   begin half = ACC_W'(32); sh = 3'd6; end
    endcase
    for (int c = 0; c < 4; c++) begin
      pre[c]  = (s2_acc[c] + half) >> sh;
      prod[c] = MUL_W'(pre[c]) * MUL_W'(RECIP9);
      res[c]  = (s2_scale == SCL_W'(3)) ? prod[c][16 +: CH_W] : pre[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tl    <= req.tl;
      s1_tr    <= req.tr;
      s1_bl    <= req.bl;
      s1_br    <= req.br;
      s1_w00   <= WP_W'(wx0) * WP_W'(wy0);
      s1_w10   <= WP_W'(wx1) * WP_W'(wy0);
      s1_w01   <= WP_W'(wx0) * WP_W'(wy1);
      s1_w11   <= WP_W'(wx1) * WP_W'(wy1);
      s1_scale <= req.scale;
      s1_dx    <= req.dx;
      s1_dy    <= req.dy;
      s1_last  <= req.last;

      s2_acc   <= acc;
      s2_scale <= s1_scale;
      s2_dx    <= s1_dx;
      s2_dy    <= s1_dy;
      s2_last  <= s1_last;

      dest_x   <= s2_dx[DX_W-1:0];
      dest_y   <= s2_dy[DY_W-1:0];
      out_ch0  <= res[0];
      out_ch1  <= res[1];
      out_ch2  <= res[2];
      out_ch3  <= res[3];
      run_last <= s2_last;
    end
  end

endmodule

[design/bilinear_upscale_integer.sv]
// Top level of the integer-factor bilinear upscaler.
// Depends on bui_pkg, bui_cfg, bui_seq (with bui_ram) and bui_mac.

// Source pixels enter in raster order, one request per pixel carrying up
// to four 8-bit channels; channels at or above channel_count are taken as
// zero. Each pixel produces every destination pixel whose four source
// neighbours are then known, row by row within its block, tagged with
// dest_x/dest_y and with run_last on the final one, so the output comes in
// block order rather than raster order. Weights are multiples of 1/(2s)
// and results round half up; scale 1 passes pixels through. Once a pixel
// is accepted the block reads the line store, then issues one result per
// cycle through the shared multiply-accumulate unit unless out_stall
// holds it: s*s results inside the image, up to 36 at the far edges for
// s = 4, 1 for pass through. in_stall is high from the line store read
// until the last result is issued. The line store holds the previous
// source row and is only used for rows after the first, so it needs no
// clearing pass after reset. The user must write configuration over APB
// only while the block is idle; the block itself does not enforce this.
// Any register write restarts the frame at the top-left pixel.

module bilinear_upscale_integer import bui_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // source pixels
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   in_ch0,
  input  logic [CH_W-1:0]   in_ch1,
  input  logic [CH_W-1:0]   in_ch2,
  input  logic [CH_W-1:0]   in_ch3,
  // destination pixels
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DX_W-1:0]   dest_x,
  output logic [DY_W-1:0]   dest_y,
  output logic [CH_W-1:0]   out_ch0,
  output logic [CH_W-1:0]   out_ch1,
  output logic [CH_W-1:0]   out_ch2,
  output logic [CH_W-1:0]   out_ch3,
  output logic              run_last
);

  cfg_t     cfg;
  mac_req_t req;
  logic     adv;   // MAC pipeline moves on this cycle

  // register file; hands on clamped values
  bui_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // walks the destination block of each source pixel, one request a cycle while adv is high
  bui_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch0   (in_ch0),
    .in_ch1   (in_ch1),
    .in_ch2   (in_ch2),
    .in_ch3   (in_ch3),
    .adv      (adv),
    .req      (req)
  );

  // weights, four-tap sum and rounding; owns the output register
  bui_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .run_last  (run_last)
  );

endmodule

[tb/bilinear_upscale_integer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_upscale_integer: directed table, then random frames.
// Depends on bui_pkg and the design; predicts every destination pixel in-house.

module bilinear_upscale_integer_tb;
  import bui_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;  // generous bound on the whole run
  localparam int SETTLE_CYCLES = 10;      // > issue-to-output latency of the block
  localparam int RANDOM_ITEMS  = 310;
  localparam int STEADY_FROM   = 120;     // random requests sent with no idling
  localparam int STEADY_TO     = 180;
  localparam int MAX_REPORTS   = 100;
  localparam int N_DIRECTED    = 40;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  // one row of the directed table: a register write or a source pixel,
  // optionally with every resulting pixel's channels typed in
  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [31:0]      value;
    logic [PIX_W-1:0] px;
    logic             typed;
    logic [PIX_W-1:0] want;
  } stim_row_t;

  typedef struct packed {
    logic [DX_W-1:0]          dx;
    logic [DY_W-1:0]          dy;
    logic [3:0][CH_W-1:0]     ch;
    logic                     last;
  } dest_px_t;

  typedef logic [3*MAX_SCALE-1:0][15:0] axis_vec_t;

  // Pixels are written ch3..ch0, so the low byte is channel 0.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // reset settings: s = 4, four channels; top-left pixel fills its block
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFF00_5AA5, 1'b1, 32'hFF00_5AA5},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h0000_0000, 1'b0, 32'h0},
    // scale 0 and channel count 0 both act as 1: grey pass-through
    '{ROW_WRITE, REG_SCALE,    32'd0,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_CHANNELS, 32'd0,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_WIDTH,    32'd3,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_HEIGHT,   32'd2,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFFFF_FFFF, 1'b1, 32'h0000_00FF},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h01FE_7F80, 1'b1, 32'h0000_0080},
    '{ROW_WRITE, REG_CHANNELS, 32'd3,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h1122_3344, 1'b1, 32'h0022_3344},
    // channel count above 4 acts as 4
    '{ROW_WRITE, REG_CHANNELS, 32'd7,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h8040_2010, 1'b1, 32'h8040_2010},
    // s = 2 on a 2x2 frame, width written with junk above its 12 bits
    '{ROW_WRITE, REG_SCALE,    32'd2,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_CHANNELS, 32'd2,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_WIDTH,    32'hFFFF_F002,  32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_HEIGHT,   32'd2,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFF00_FF00, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h00FF_00FF, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h7F80_7F80, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h0102_0304, 1'b0, 32'h0},
    // frame wrapped: back at the top-left, two channels in use
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hAABB_CCDD, 1'b1, 32'h0000_CCDD},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h1234_5678, 1'b0, 32'h0},
    // odd scale on a one-column image
    '{ROW_WRITE, REG_SCALE,    32'd3,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_CHANNELS, 32'd4,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_WIDTH,    32'd1,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_HEIGHT,   32'd3,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h00FF_7F80, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFF00_807F, 1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h55AA_55AA, 1'b0, 32'h0},
    // scale above 4 saturates; zero width and height act as 1x1 frames
    '{ROW_WRITE, REG_SCALE,    32'd7,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_WIDTH,    32'd0,          32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_HEIGHT,   32'd0,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hC0FF_EE00, 1'b1, 32'hC0FF_EE00},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h0000_0000, 1'b1, 32'h0000_0000},
    // oversized width and height saturate
    '{ROW_WRITE, REG_WIDTH,    32'd4095,       32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_HEIGHT,   32'd16383,      32'h0,         1'b0, 32'h0},
    '{ROW_WRITE, REG_SCALE,    32'd4,          32'h0,         1'b0, 32'h0},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'h5A5A_5AA5, 1'b1, 32'h5A5A_5AA5},
    '{ROW_PIXEL, REG_SCALE,    32'd0,          32'hFFFF_FFFF, 1'b0, 32'h0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CH_W-1:0]   in_ch0 = '0;
  logic [CH_W-1:0]   in_ch1 = '0;
  logic [CH_W-1:0]   in_ch2 = '0;
  logic [CH_W-1:0]   in_ch3 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DX_W-1:0]   dest_x;
  logic [DY_W-1:0]   dest_y;
  logic [CH_W-1:0]   out_ch0;
  logic [CH_W-1:0]   out_ch1;
  logic [CH_W-1:0]   out_ch2;
  logic [CH_W-1:0]   out_ch3;
  logic              run_last;

  bilinear_upscale_integer dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch0    (in_ch0),
    .in_ch1    (in_ch1),
    .in_ch2    (in_ch2),
    .in_ch3    (in_ch3),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .run_last  (run_last)
  );

  // ---------------------------------------------------------------------
  // Predictor state: own copy of the registers, counters and line store.
  // ---------------------------------------------------------------------
  logic [SCL_W-1:0] scale_reg  = 3'd4;
  logic [CHN_W-1:0] chans_reg  = 3'd4;
  logic [11:0]      width_reg  = 12'd2048;
  logic [13:0]      height_reg = 14'd8192;
  logic [PIX_W-1:0] line_mem [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] left_cur   = '0;   // previous pixel of this row
  logic [PIX_W-1:0] left_above = '0;   // the pixel above that one
  int               col_cnt    = 0;
  int               row_cnt    = 0;

  dest_px_t dest_px_due [$];           // destination pixels still to arrive
  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       cycle_count    = 0;
  bit       steady         = 1'b0;     // suppresses idling on both sides

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Destination indices on one axis whose far neighbour is source index p,
  // with their near neighbour and fraction (out of 2s).
  function automatic int axis_span(input int p, input int s, input int n,
                                   output axis_vec_t dst, output axis_vec_t near_i,
                                   output axis_vec_t frac);
    int cnt, d, lo_d, hi_d, num, i, far;
    cnt  = 0;
    dst  = '0;
    near_i = '0;
    frac = '0;
    lo_d = (p >= 1) ? (p - 1) * s : 0;
    hi_d = (p + 2) * s;
    if (hi_d > n * s) hi_d = n * s;
    for (d = lo_d; d < hi_d && cnt < 3 * MAX_SCALE; d++) begin
      num = 2 * d + 1 - s;
      i   = (num >= 0) ? num / (2 * s) : -1;
      far = (i + 1 > n - 1) ? n - 1 : i + 1;
      if (far == p) begin
        dst[cnt]    = 16'(d);
        near_i[cnt] = 16'((i < 0) ? 0 : i);
        frac[cnt]   = 16'(num - 2 * s * i);
        cnt++;
      end
    end
    return cnt;
  endfunction

  // Work out every destination pixel caused by one accepted source request.
  // With use_want set, the channels of each are taken from want instead.
  function automatic void upscale_request(logic [PIX_W-1:0] raw, logic use_want,
                                          logic [PIX_W-1:0] want);
    int s, nch, w, h, x, y, nr, nc, r, k, c, full, wx0, wx1, wy0, wy1, acc;
    logic [PIX_W-1:0] cur, above, top_r, top_l, tl, bl;
    axis_vec_t rd, rn, rf, cd, cn, cf;
    dest_px_t o;
    s   = clampi(scale_reg, 1, MAX_SCALE);
    nch = clampi(chans_reg, 1, 4);
    w   = clampi(width_reg, 1, MAX_WIDTH_DEF);
    h   = clampi(height_reg, 1, MAX_HEIGHT);
    x   = (col_cnt >= w) ? w - 1 : col_cnt;
    y   = (row_cnt >= h) ? h - 1 : row_cnt;
    cur = '0;
    for (c = 0; c < nch; c++) cur[8*c +: 8] = raw[8*c +: 8];
    above = line_mem[x];
    if (s == 1) begin
      o.dx   = DX_W'(x);
      o.dy   = DY_W'(y);
      o.ch   = use_want ? want : cur;
      o.last = 1'b1;
      dest_px_due.push_back(o);
    end else begin
      nr   = axis_span(y, s, h, rd, rn, rf);
      nc   = axis_span(x, s, w, cd, cn, cf);
      full = 2 * s;
      for (r = 0; r < nr; r++) begin
        // top pair comes from the current row when clamped at the top edge
        top_r = (rn[r] == y) ? cur : above;
        top_l = (rn[r] == y) ? left_cur : left_above;
        wy1 = rf[r];
        wy0 = full - wy1;
        for (k = 0; k < nc; k++) begin
          wx1 = cf[k];
          wx0 = full - wx1;
          tl  = (cn[k] == x) ? top_r : top_l;
          bl  = (cn[k] == x) ? cur : left_cur;
          o.dx = DX_W'(cd[k]);
          o.dy = DY_W'(rd[r]);
          for (c = 0; c < 4; c++) begin
            acc = tl[8*c +: 8] * wx0 * wy0 + top_r[8*c +: 8] * wx1 * wy0
                + bl[8*c +: 8] * wx0 * wy1 + cur[8*c +: 8] * wx1 * wy1;
            o.ch[c] = CH_W'((acc + 2 * s * s) / (4 * s * s));
          end
          if (use_want) o.ch = want;
          o.last = (r == nr - 1) && (k == nc - 1);
          dest_px_due.push_back(o);
        end
      end
    end
    line_mem[x] = cur;
    left_above  = above;
    left_cur    = cur;
    if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: got %0d, expected %0d (result %0d, t=%0t)",
               what, got, want, results_seen, $realtime);
  endtask

  function automatic logic [CH_W-1:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  // Occasionally fills the bits above a register's width with junk.
  function automatic logic [31:0] with_noise(logic [31:0] v, int bits);
    return ($urandom_range(3) == 0) ? (v | ($urandom() << bits)) : v;
  endfunction

  // ---------------------------------------------------------------------
  // Request side: one source pixel per call, held until accepted.
  // ---------------------------------------------------------------------
  task automatic send_request(logic [PIX_W-1:0] px, logic use_want, logic [PIX_W-1:0] want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_ch3, in_ch2, in_ch1, in_ch0} <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    upscale_request(px, use_want, want);
  endtask

  // Stop sending and wait until the block has delivered everything.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dest_px_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access phase; the predictor follows at the
  // completing edge, and any write restarts the frame.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SCALE:    scale_reg  = val[SCL_W-1:0];
      REG_CHANNELS: chans_reg  = val[CHN_W-1:0];
      REG_WIDTH:    width_reg  = val[11:0];
      REG_HEIGHT:   height_reg = val[13:0];
      default: ;
    endcase
    col_cnt = 0;
    row_cnt = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stall, off during the steady stretch.
  always @(negedge clk)
    out_stall <= !rst && !steady && ($urandom_range(99) < 31);

  // Every accepted destination pixel is matched against the oldest one due.
  always @(posedge clk) begin
    dest_px_t             due;
    logic [3:0][CH_W-1:0] got_ch;
    int                   c;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (dest_px_due.size() == 0) begin
        report_mismatch("unexpected result, dest_x", dest_x, 0);
      end else begin
        due    = dest_px_due.pop_front();
        got_ch = {out_ch3, out_ch2, out_ch1, out_ch0};
        if (dest_x !== due.dx) report_mismatch("dest_x", dest_x, due.dx);
        if (dest_y !== due.dy) report_mismatch("dest_y", dest_y, due.dy);
        for (c = 0; c < 4; c++)
          if (got_ch[c] !== due.ch[c])
            report_mismatch($sformatf("out_ch%0d at (%0d,%0d)", c, due.dx, due.dy),
                            got_ch[c], due.ch[c]);
        if (run_last !== due.last) report_mismatch("run_last", run_last, due.last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then random frames with random settings.
  // ---------------------------------------------------------------------
  initial begin
    int  row, sent, n_phase, j, fw, fh;
    logic [31:0] val;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part; writes only once the block has gone quiet
    for (row = 0; row < N_DIRECTED; row++) begin
      if (DIRECTED[row].kind == ROW_WRITE) begin
        drain();
        write_reg(DIRECTED[row].reg_idx, DIRECTED[row].value);
      end else begin
        send_request(DIRECTED[row].px, DIRECTED[row].typed, DIRECTED[row].want);
      end
    end

    // random part: each phase rewrites some registers, then streams
    // enough pixels to cover a frame or so (frames are kept small)
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(3) != 0) begin
        val = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
        write_reg(REG_SCALE, with_noise(val, SCL_W));
      end
      if ($urandom_range(3) != 0) write_reg(REG_CHANNELS, with_noise($urandom_range(7), CHN_W));
      if ($urandom_range(3) != 0) begin
        val = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        write_reg(REG_WIDTH, with_noise(val, 12));
      end
      if ($urandom_range(3) != 0) write_reg(REG_HEIGHT, with_noise($urandom_range(0, 5), 14));
      fw = clampi(width_reg, 1, MAX_WIDTH_DEF);
      fh = clampi(height_reg, 1, MAX_HEIGHT);
      n_phase = clampi(fw * fh + $urandom_range(0, 3), 2, 40);
      for (j = 0; j < n_phase && sent < RANDOM_ITEMS; j++) begin
        steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);
        // now and then hold off until the block has caught up
        if ($urandom_range(49) == 0) drain();
        send_request({rand_byte(), rand_byte(), rand_byte(), rand_byte()}, 1'b0, '0);
        sent++;
      end
    end
    steady = 1'b0;
    drain();

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
